>>> src/assert_macros.svh
// Assertion helpers for the picture unit register port.
// Every property is sampled on clk and is ignored while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define PPURT_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define PPURT_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`else

`define PPURT_ASSERT(label, prop, msg)

`define PPURT_ASSERT_IMP(label, ante, cons, msg)

`endif

`endif

>>> src/ppurt_pkg.sv
package ppurt_pkg;

	// Request function codes.
	localparam logic [2:0] FUNC_TICK  = 3'd0;
	localparam logic [2:0] FUNC_READ  = 3'd1;
	localparam logic [2:0] FUNC_PEEK  = 3'd2;
	localparam logic [2:0] FUNC_WRITE = 3'd3;
	localparam logic [2:0] FUNC_CLEAR = 3'd4;

	// Register numbers.
	localparam logic [2:0] REG_CTRL   = 3'd0;
	localparam logic [2:0] REG_MASK   = 3'd1;
	localparam logic [2:0] REG_STATUS = 3'd2;
	localparam logic [2:0] REG_ADDR   = 3'd6;
	localparam logic [2:0] REG_DATA   = 3'd7;

	// Frame timing.
	localparam logic [8:0]        DOT_WRAP  = 9'd341;
	localparam logic [8:0]        VBL_DOT   = 9'd1;
	localparam logic signed [9:0] LINE_WRAP = 10'sd261;
	localparam logic signed [9:0] VBL_LINE  = 10'sd241;
	localparam logic signed [9:0] PRE_LINE  = -10'sd1;

	// Register port constants.
	localparam logic [15:0] PALETTE_BASE = 16'h3F00;
	localparam logic [15:0] STEP_WIDE    = 16'd32;
	localparam logic [15:0] STEP_NARROW  = 16'd1;
	localparam logic [7:0]  NO_DATA      = 8'hFF;
	localparam logic [1:0]  STATUS_FIXED = 2'b01;
	localparam int          CTRL_NMI_EN  = 7;
	localparam int          CTRL_STEP    = 2;

	typedef struct packed {
		logic vbl_set;
		logic vbl_clr;
		logic frame_wrap;
	} timing_evt_t;

endpackage

>>> src/ppurt_timing.sv
module ppurt_timing (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      tick,
	output logic [8:0]                cycle_nxt,
	output logic signed [9:0]         scanline_nxt,
	output ppurt_pkg::timing_evt_t    evt
);
	import ppurt_pkg::*;

	logic [8:0]        dot_q;
	logic signed [9:0] line_q;
	logic [8:0]        dot_w;
	logic signed [9:0] line_w;
	logic signed [9:0] line_inc;
	logic              wrap;

	always_comb begin
		// Blank events look at the counters as they stand before the step.
		evt.vbl_set = (line_q == VBL_LINE) && (dot_q == VBL_DOT);
		evt.vbl_clr = (line_q == PRE_LINE) && (dot_q == VBL_DOT);
		line_inc    = line_q + 10'sd1;
		dot_w       = dot_q;
		line_w      = line_q;
		wrap        = 1'b0;
		if (dot_q >= DOT_WRAP) begin
			dot_w = '0;
			if (line_inc >= LINE_WRAP) begin
				line_w = PRE_LINE;
				wrap   = 1'b1;
			end else begin
				line_w = line_inc;
			end
		end
		evt.frame_wrap = tick && wrap;
		cycle_nxt      = tick ? dot_w + 9'd1 : dot_q;
		scanline_nxt   = tick ? line_w : line_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_q  <= '0;
			line_q <= '0;
		end else if (tick) begin
			dot_q  <= cycle_nxt;
			line_q <= scanline_nxt;
		end
	end

endmodule

>>> src/ppu_register_port_and_frame_timing_core.sv
// CPU register port and frame timing of a console picture unit.
// Requests arrive on req_valid/req_ready with func, reg_index, write_data and
// mem_read_data; each request gives exactly one response on
// rsp_valid/rsp_ready carrying read_data, the video address, the video
// memory write strobe and byte, the sticky nmi level and the dot and line
// counters after the request.
// A request is taken into an input register, evaluated in one pass against
// the register file and counters, and moves to the response register once it
// is empty or being taken: one request per cycle sustained while rsp_ready
// stays high. The response register and the input register each hold one
// request, so a new request is taken while a finished response waits.
// When the receiver stalls, both stages fill and req_ready drops; it rises
// again in the cycle the response is taken.
// Reset clears both stages and loads control 0x00, mask 0x00, vertical blank
// set, latch 0, address 0x0000, read buffer 0x00, nmi 0, dot 0 and line 0.
`include "assert_macros.svh"

module ppu_register_port_and_frame_timing_core (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  logic [2:0]          func,
	input  logic [2:0]          reg_index,
	input  logic [7:0]          write_data,
	input  logic [7:0]          mem_read_data,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output logic [7:0]          read_data,
	output logic [15:0]         vram_address,
	output logic                vram_write,
	output logic [7:0]          vram_write_data,
	output logic                nmi,
	output logic [8:0]          cycle,
	output logic signed [9:0]   scanline,
	output logic                frame_done
);
	import ppurt_pkg::*;

	// Input stage.
	logic       valid_s1;
	logic [2:0] func_s1;
	logic [2:0] reg_s1;
	logic [7:0] wdata_s1;
	logic [7:0] mem_s1;

	// Architectural state.
	logic [7:0]  ctrl_q;
	logic [7:0]  mask_q;
	logic        vbl_q;
	logic        latch_q;
	logic [15:0] addr_q;
	logic [7:0]  rbuf_q;
	logic        nmi_q;

	logic [7:0]  ctrl_n;
	logic        vbl_n;
	logic        latch_n;
	logic [15:0] addr_n;
	logic [7:0]  rbuf_n;
	logic        nmi_n;
	logic [7:0]  mask_n;
	logic [7:0]  rd_n;
	logic        vw_n;
	logic [7:0]  vwd_n;
	logic [15:0] step;

	logic              advance;
	logic              tick;
	logic [8:0]        cycle_nxt;
	logic signed [9:0] scanline_nxt;
	timing_evt_t       evt;
	logic              at_wrap_pos;

	assign advance   = valid_s1 && (!rsp_valid || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign tick      = advance && (func_s1 == FUNC_TICK);

	ppurt_timing u_timing (
		.clk          (clk),
		.arst_n       (arst_n),
		.tick         (tick),
		.cycle_nxt    (cycle_nxt),
		.scanline_nxt (scanline_nxt),
		.evt          (evt)
	);

	always_comb begin
		ctrl_n  = ctrl_q;
		mask_n  = mask_q;
		vbl_n   = vbl_q;
		latch_n = latch_q;
		addr_n  = addr_q;
		rbuf_n  = rbuf_q;
		nmi_n   = nmi_q;
		rd_n    = NO_DATA;
		vw_n    = 1'b0;
		vwd_n   = '0;
		step    = ctrl_q[CTRL_STEP] ? STEP_WIDE : STEP_NARROW;
		case (func_s1)
			FUNC_TICK: begin
				if (evt.vbl_clr)
					vbl_n = 1'b0;
				if (evt.vbl_set)
					vbl_n = 1'b1;
				if (vbl_n && ctrl_q[CTRL_NMI_EN])
					nmi_n = 1'b1;
			end
			FUNC_READ, FUNC_PEEK: begin
				unique case (reg_s1)
					REG_CTRL: begin
						if (func_s1 == FUNC_PEEK)
							rd_n = ctrl_q;
					end
					REG_MASK: begin
						if (func_s1 == FUNC_PEEK)
							rd_n = mask_q;
					end
					REG_STATUS: begin
						rd_n = {vbl_q, STATUS_FIXED, rbuf_q[4:0]};
						if (func_s1 == FUNC_READ) begin
							vbl_n   = 1'b0;
							latch_n = 1'b0;
						end
					end
					REG_DATA: begin
						if (func_s1 == FUNC_PEEK) begin
							rd_n = rbuf_q;
						end else begin
							// Palette space bypasses the read buffer.
							rd_n   = (addr_q >= PALETTE_BASE) ? mem_s1 : rbuf_q;
							rbuf_n = mem_s1;
							addr_n = addr_q + step;
						end
					end
					default: rd_n = NO_DATA;
				endcase
			end
			FUNC_WRITE: begin
				unique case (reg_s1)
					REG_CTRL: ctrl_n = wdata_s1;
					REG_MASK: mask_n = wdata_s1;
					REG_ADDR: begin
						if (!latch_q)
							addr_n = {wdata_s1, addr_q[7:0]};
						else
							addr_n = {addr_q[15:8], wdata_s1};
						latch_n = !latch_q;
					end
					REG_DATA: begin
						vw_n   = 1'b1;
						vwd_n  = wdata_s1;
						addr_n = addr_q + step;
					end
					default: ;
				endcase
			end
			FUNC_CLEAR: begin
				nmi_n              = 1'b0;
				ctrl_n[CTRL_NMI_EN] = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			func_s1  <= func;
			reg_s1   <= reg_index;
			wdata_s1 <= write_data;
			mem_s1   <= mem_read_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q  <= 8'h00;
			mask_q  <= 8'h00;
			vbl_q   <= 1'b1;
			latch_q <= 1'b0;
			addr_q  <= 16'h0000;
			rbuf_q  <= 8'h00;
			nmi_q   <= 1'b0;
		end else if (advance) begin
			ctrl_q  <= ctrl_n;
			mask_q  <= mask_n;
			vbl_q   <= vbl_n;
			latch_q <= latch_n;
			addr_q  <= addr_n;
			rbuf_q  <= rbuf_n;
			nmi_q   <= nmi_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (advance) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			read_data       <= rd_n;
			vram_address    <= addr_n;
			vram_write      <= vw_n;
			vram_write_data <= vwd_n;
			nmi             <= nmi_n;
			cycle           <= cycle_nxt;
			scanline        <= scanline_nxt;
			frame_done      <= evt.frame_wrap;
		end
	end

	assign at_wrap_pos = (scanline == PRE_LINE) && (cycle == VBL_DOT);

	`PPURT_ASSERT_IMP(a_write_no_read, rsp_valid && vram_write, read_data == NO_DATA, "read on write")
	`PPURT_ASSERT_IMP(a_frame_pos, rsp_valid && frame_done, at_wrap_pos, "frame wrap misplaced")
	`PPURT_ASSERT_IMP(a_dot_range, rsp_valid, cycle <= DOT_WRAP, "dot counter out of range")
	`PPURT_ASSERT_IMP(a_nmi_on_tick, $rose(nmi_q), $past(tick), "nmi rose without a tick")

endmodule

>>> tb/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ppurt_pkg::*;

	// Registers and function codes the package leaves unnamed.
	localparam logic [2:0] REG_OAM_ADDR  = 3'd3;
	localparam logic [2:0] REG_OAM_DATA  = 3'd4;
	localparam logic [2:0] REG_SCROLL    = 3'd5;
	localparam logic [2:0] FUNC_SPARE_LO = 3'd5;
	localparam logic [2:0] FUNC_SPARE_HI = 3'd7;

	localparam int RANDOM_ACCESSES = 420;
	localparam int QUIET_LIMIT     = 4000;
	localparam int TAIL_CYCLES     = 8;
	localparam int STEADY_FROM     = 200;
	localparam int STEADY_TO       = 350;

	typedef struct {
		logic [2:0] func;
		logic [2:0] reg_index;
		logic [7:0] write_data;
		logic [7:0] mem_read_data;
		bit         drain;
	} bus_req_t;

	typedef struct packed {
		logic [7:0]        read_data;
		logic [15:0]       vram_address;
		logic              vram_write;
		logic [7:0]        vram_write_data;
		logic              nmi;
		logic [8:0]        cycle;
		logic signed [9:0] scanline;
		logic              frame_done;
	} bus_rsp_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	logic [2:0] func = FUNC_TICK;
	logic [2:0] reg_index = REG_CTRL;
	logic [7:0] write_data = 8'h00;
	logic [7:0] mem_read_data = 8'h00;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	logic [7:0] read_data;
	logic [15:0] vram_address;
	logic vram_write;
	logic [7:0] vram_write_data;
	logic nmi;
	logic [8:0] cycle;
	logic signed [9:0] scanline;
	logic frame_done;

	ppu_register_port_and_frame_timing_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.func(func),
		.reg_index(reg_index),
		.write_data(write_data),
		.mem_read_data(mem_read_data),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.read_data(read_data),
		.vram_address(vram_address),
		.vram_write(vram_write),
		.vram_write_data(vram_write_data),
		.nmi(nmi),
		.cycle(cycle),
		.scanline(scanline),
		.frame_done(frame_done)
	);

	always #6 clk = ~clk;

	bus_req_t req_backlog[$];
	bus_rsp_t predicted_rsp[$];
	bus_req_t presented_req;
	int req_count = 0;
	int rsp_count = 0;
	int mismatches = 0;
	int cyc = 0;
	int quiet = 0;

	// Shadow of the register port and frame counters.
	logic [7:0]        ctrl_q;
	logic [7:0]        mask_q;
	logic [7:0]        status_q;
	logic              latch_q;
	logic [15:0]       vaddr_q;
	logic [7:0]        rbuf_q;
	logic              nmi_q;
	logic [8:0]        dot_q;
	logic signed [9:0] line_q;

	function automatic bus_rsp_t advance_port(input bus_req_t r);
		bus_rsp_t o;
		logic [15:0] step;
		logic peek;
		o.read_data = NO_DATA;
		o.vram_write = 1'b0;
		o.vram_write_data = 8'h00;
		o.frame_done = 1'b0;
		step = ctrl_q[CTRL_STEP] ? STEP_WIDE : STEP_NARROW;
		peek = (r.func == FUNC_PEEK);
		case (r.func)
			FUNC_TICK: begin
				if (line_q == PRE_LINE && dot_q == VBL_DOT)
					status_q[7] = 1'b0;
				if (line_q == VBL_LINE && dot_q == VBL_DOT)
					status_q[7] = 1'b1;
				if (status_q[7] && ctrl_q[CTRL_NMI_EN])
					nmi_q = 1'b1;
				if (dot_q >= DOT_WRAP) begin
					dot_q = 9'd0;
					line_q = line_q + 10'sd1;
					if (line_q >= LINE_WRAP) begin
						line_q = PRE_LINE;
						o.frame_done = 1'b1;
					end
				end
				dot_q = dot_q + 9'd1;
			end
			FUNC_READ, FUNC_PEEK: begin
				case (r.reg_index)
					REG_CTRL: if (peek) o.read_data = ctrl_q;
					REG_MASK: if (peek) o.read_data = mask_q;
					REG_STATUS: begin
						o.read_data = {status_q[7:5], rbuf_q[4:0]};
						if (!peek) begin
							status_q[7] = 1'b0;
							latch_q = 1'b0;
						end
					end
					REG_DATA: begin
						if (peek) begin
							o.read_data = rbuf_q;
						end else begin
							// Palette space bypasses the read buffer.
							o.read_data = (vaddr_q >= PALETTE_BASE) ? r.mem_read_data : rbuf_q;
							rbuf_q = r.mem_read_data;
							vaddr_q = vaddr_q + step;
						end
					end
					default: ;
				endcase
			end
			FUNC_WRITE: begin
				case (r.reg_index)
					REG_CTRL: ctrl_q = r.write_data;
					REG_MASK: mask_q = r.write_data;
					REG_ADDR: begin
						if (!latch_q)
							vaddr_q[15:8] = r.write_data;
						else
							vaddr_q[7:0] = r.write_data;
						latch_q = ~latch_q;
					end
					REG_DATA: begin
						o.vram_write = 1'b1;
						o.vram_write_data = r.write_data;
						vaddr_q = vaddr_q + step;
					end
					default: ;
				endcase
			end
			FUNC_CLEAR: begin
				nmi_q = 1'b0;
				ctrl_q[CTRL_NMI_EN] = 1'b0;
			end
			default: ;
		endcase
		o.vram_address = vaddr_q;
		o.nmi = nmi_q;
		o.cycle = dot_q;
		o.scanline = line_q;
		return o;
	endfunction

	function automatic bus_req_t mk_req(input logic [2:0] f, input logic [2:0] ri,
			input logic [7:0] wd, input logic [7:0] md);
		bus_req_t r;
		r.func = f;
		r.reg_index = ri;
		r.write_data = wd;
		r.mem_read_data = md;
		r.drain = 1'b0;
		return r;
	endfunction

	function automatic bus_req_t random_req();
		bus_req_t r;
		int pick;
		pick = $urandom_range(99);
		if (pick < 30)
			r.func = FUNC_TICK;
		else if (pick < 55)
			r.func = FUNC_READ;
		else if (pick < 68)
			r.func = FUNC_PEEK;
		else if (pick < 94)
			r.func = FUNC_WRITE;
		else if (pick < 97)
			r.func = FUNC_CLEAR;
		else
			r.func = 3'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
		// Lean on the registers that carry state.
		case ($urandom_range(4))
			0: r.reg_index = REG_STATUS;
			1: r.reg_index = REG_ADDR;
			2: r.reg_index = REG_DATA;
			default: r.reg_index = 3'($urandom_range(7));
		endcase
		r.write_data = 8'($urandom_range(255));
		r.mem_read_data = 8'($urandom_range(255));
		r.drain = 1'b0;
		return r;
	endfunction

	task automatic queue_req(input bus_req_t r, input bit drain);
		r.drain = drain;
		req_backlog.push_back(r);
	endtask

	// Request driver.
	always @(posedge clk or negedge arst_n) begin
		bit took;
		bit hold;
		bus_req_t nxt;
		if (!arst_n) begin
			req_valid <= 1'b0;
			func <= FUNC_TICK;
			reg_index <= REG_CTRL;
			write_data <= 8'h00;
			mem_read_data <= 8'h00;
			req_count <= 0;
			ctrl_q = 8'h00;
			mask_q = 8'h00;
			status_q = {1'b1, STATUS_FIXED, 5'd0};
			latch_q = 1'b0;
			vaddr_q = 16'h0000;
			rbuf_q = 8'h00;
			nmi_q = 1'b0;
			dot_q = 9'd0;
			line_q = 10'sd0;
		end else begin
			took = req_valid && req_ready;
			if (took) begin
				predicted_rsp.push_back(advance_port(presented_req));
				req_count <= req_count + 1;
			end
			if (!req_valid || took) begin
				hold = (req_backlog.size() == 0);
				if (!hold && !(cyc >= STEADY_FROM && cyc < STEADY_TO))
					hold = ($urandom_range(99) < 17);
				// A drain request waits until every response is back.
				if (!hold && req_backlog[0].drain)
					hold = (req_count + int'(took) != rsp_count);
				if (hold) begin
					req_valid <= 1'b0;
				end else begin
					nxt = req_backlog.pop_front();
					presented_req <= nxt;
					req_valid <= 1'b1;
					func <= nxt.func;
					reg_index <= nxt.reg_index;
					write_data <= nxt.write_data;
					mem_read_data <= nxt.mem_read_data;
				end
			end
		end
	end

	// Response monitor.
	always @(posedge clk or negedge arst_n) begin
		bus_rsp_t got;
		bus_rsp_t want;
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_count <= 0;
		end else begin
			rsp_ready <= (cyc >= STEADY_FROM && cyc < STEADY_TO) || ($urandom_range(99) >= 17);
			if (rsp_valid && rsp_ready) begin
				got.read_data = read_data;
				got.vram_address = vram_address;
				got.vram_write = vram_write;
				got.vram_write_data = vram_write_data;
				got.nmi = nmi;
				got.cycle = cycle;
				got.scanline = scanline;
				got.frame_done = frame_done;
				rsp_count <= rsp_count + 1;
				if (rsp_count >= req_count) begin
					if (mismatches < 10)
						$display("response %0d arrived with no request outstanding", rsp_count);
					mismatches++;
				end else begin
					want = predicted_rsp.pop_front();
					if (got !== want) begin
						if (mismatches < 10) begin
							$display("response %0d mismatch (expected/actual): read_data %h/%h",
								rsp_count, want.read_data, got.read_data);
							$display("  vram_address %h/%h vram_write %b/%b vram_write_data %h/%h",
								want.vram_address, got.vram_address,
								want.vram_write, got.vram_write,
								want.vram_write_data, got.vram_write_data);
							$display("  nmi %b/%b cycle %0d/%0d scanline %0d/%0d frame_done %b/%b",
								want.nmi, got.nmi, want.cycle, got.cycle,
								want.scanline, got.scanline,
								want.frame_done, got.frame_done);
						end
						mismatches++;
					end
				end
			end
		end
	end

	// Watchdog on cycles with no request or response moving.
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (!arst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet <= 0;
		end else if (quiet >= QUIET_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end else begin
			quiet <= quiet + 1;
		end
	end

	initial begin
		// Vertical blank is set out of reset, so enabling the interrupt and
		// ticking raises it at once.
		queue_req(mk_req(FUNC_WRITE, REG_CTRL, 8'h80, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_TICK, REG_CTRL, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_TICK, REG_CTRL, 8'h00, 8'h00), 1'b0);
		// Status reads and peeks from reset, then palette and buffered data
		// accesses, address wrap with the wide step, ignored registers and
		// the unused function codes.
		queue_req(mk_req(FUNC_PEEK, REG_CTRL, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_READ, REG_CTRL, 8'h00, 8'hFF), 1'b0);
		queue_req(mk_req(FUNC_PEEK, REG_STATUS, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_READ, REG_STATUS, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_PEEK, REG_STATUS, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_ADDR, 8'h3F, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_ADDR, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_READ, REG_DATA, 8'h00, 8'h5A), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_CTRL, 8'h04, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_DATA, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_ADDR, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_ADDR, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_DATA, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_READ, REG_DATA, 8'h00, 8'hA5), 1'b0);
		queue_req(mk_req(FUNC_PEEK, REG_DATA, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_MASK, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_PEEK, REG_MASK, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_STATUS, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_OAM_ADDR, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_OAM_DATA, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_SCROLL, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_READ, REG_OAM_ADDR, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_PEEK, REG_ADDR, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_WRITE, REG_CTRL, 8'hFF, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_CLEAR, REG_CTRL, 8'h00, 8'h00), 1'b0);
		queue_req(mk_req(FUNC_SPARE_LO, REG_DATA, 8'hFF, 8'hFF), 1'b0);
		queue_req(mk_req(FUNC_SPARE_HI, REG_DATA, 8'hFF, 8'hFF), 1'b0);

		for (int i = 0; i < RANDOM_ACCESSES; i++)
			queue_req(random_req(), i == RANDOM_ACCESSES / 2);

		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		while (!(req_backlog.size() == 0 && !req_valid && req_count == rsp_count))
			@(negedge clk);
		repeat (TAIL_CYCLES) @(negedge clk);

		if (predicted_rsp.size() != 0) begin
			if (mismatches < 10)
				$display("%0d responses never arrived", predicted_rsp.size());
			mismatches++;
		end
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

>>> ppu_register_port_and_frame_timing_core.f
+incdir+src
src/ppurt_pkg.sv
src/ppurt_timing.sv
src/ppu_register_port_and_frame_timing_core.sv
tb/tb.sv
